// ===== rtl/core/crc_checked_status_frame_decoder_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the status frame decoder
// Shared property forms. They expect clk and rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef CRC_CHECKED_STATUS_FRAME_DECODER_MACROS_SVH
`define CRC_CHECKED_STATUS_FRAME_DECODER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CSFD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CSFD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/csfd_pkg.sv =====
// ----------------------------------------------------------------------------
// csfd_pkg
// Types, constants and the CRC step shared by the frame decoder modules.
// ----------------------------------------------------------------------------
package csfd_pkg;

    localparam int STORE_BYTES = 30;
    localparam int CRC_BYTES   = 28;
    localparam int JOB_BYTES   = 24;
    localparam int STORE_IDX_W = 5;

    localparam logic [15:0] MODBUS_POLY_REFL = 16'hA001;
    localparam logic [15:0] CRC_INIT         = 16'hFFFF;

    typedef enum logic [2:0] {
        REC_GAME   = 3'd0,
        REC_CAR_A  = 3'd1,
        REC_CAR_B  = 3'd2,
        REC_PASS0  = 3'd3,
        REC_PASS1  = 3'd4,
        REC_REJECT = 3'd5
    } rec_kind_t;

    typedef logic [JOB_BYTES-1:0][7:0] job_bytes_t;

    typedef struct packed {
        logic       ok;
        job_bytes_t bytes;
    } frame_job_t;

    typedef struct packed {
        logic       valid;
        frame_job_t job;
    } queue_head_t;

    typedef struct packed {
        rec_kind_t   record_kind;
        logic [8:0]  pos_x;
        logic [8:0]  pos_y;
        logic        flag_bit;
        logic        task_bit;
        logic [1:0]  game_state;
        logic [15:0] value_word;
        logic [7:0]  count_pick;
        logic [7:0]  count_get;
        logic [7:0]  count_send;
        logic        last_record;
    } record_t;

    // Reflected CRC-16 update over one byte, eight shift steps.
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++)
        begin
            c = c[0] ? ((c >> 1) ^ MODBUS_POLY_REFL) : (c >> 1);
        end
        return c;
    endfunction

endpackage

// ===== rtl/core/crc_checked_status_frame_decoder.sv =====
// ----------------------------------------------------------------------------
// crc_checked_status_frame_decoder
// Checks a CRC-16/MODBUS protected status frame and emits its records.
//
//   Channel   Dir   tdata / tuser / tlast
//   s_axis    in    byte_value / - / frame_end
//   m_axis    out   packed record fields / record_kind / last_record
//
// One byte is taken per cycle while the queue has room; the byte CRC update is combinational.
// A good frame yields five records and a bad or short one yields one reject,
// each record leaving the output register once the one before has been taken.
// A two-frame queue lets the input run on while records are still sent.
// The input stalls only while that queue is full. Reset is asynchronous.
// ----------------------------------------------------------------------------
`include "crc_checked_status_frame_decoder_macros.svh"

module crc_checked_status_frame_decoder #(
    parameter int FRAME_BYTES = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // byte_value[7:0]
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // pos_x, pos_y, flag_bit, task_bit, game_state,
                                   // value_word, count_pick, count_get, count_send
    output logic [2:0]  m_tuser,   // record_kind
    output logic        m_tlast
);
    import csfd_pkg::*;

    logic        q_full;
    logic        q_push;
    logic        q_pop;
    frame_job_t  q_job;
    queue_head_t q_head;
    record_t     rec;

    csfd_front #(
        .FRAME_BYTES(FRAME_BYTES)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .byte_value(s_tdata),
        .frame_end (s_tlast),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .full      (q_full),
        .push      (q_push),
        .job       (q_job)
    );

    csfd_queue u_queue (
        .clk  (clk),
        .rst_n(rst_n),
        .push (q_push),
        .job  (q_job),
        .pop  (q_pop),
        .full (q_full),
        .head (q_head)
    );

    csfd_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .head     (q_head),
        .pop      (q_pop),
        .out_valid(m_tvalid),
        .out_ready(m_tready),
        .out_rec  (rec)
    );

    assign m_tdata = {2'b00, rec.count_send, rec.count_get, rec.count_pick,
                      rec.value_word, rec.game_state, rec.task_bit, rec.flag_bit,
                      rec.pos_y, rec.pos_x};
    assign m_tuser = rec.record_kind;
    assign m_tlast = rec.last_record;

    `CSFD_ASSERT_NOW(a_reject_is_last, m_tvalid && (m_tuser == REC_REJECT), m_tlast, "reject record not last")
    `CSFD_ASSERT_NOW(a_pass1_is_last, m_tvalid && (m_tuser == REC_PASS1), m_tlast, "passenger 1 record not last")
    `CSFD_ASSERT_NOW(a_last_kind, m_tvalid && !m_tlast, m_tuser < REC_PASS1, "bad kind before frame end")
    `CSFD_ASSERT_NEXT(a_records_follow, m_tvalid && m_tready && !m_tlast, m_tvalid && (m_tuser == $past(m_tuser) + 3'd1), "record sequence broken")

endmodule

// ===== rtl/core/csfd_front.sv =====
// ----------------------------------------------------------------------------
// csfd_front
// Takes frame bytes, keeps the first 30, runs the CRC and hands a checked
// frame to the queue at frame end.
// ----------------------------------------------------------------------------
module csfd_front #(
    parameter int FRAME_BYTES = 32
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [7:0]           byte_value,
    input  logic                 frame_end,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 full,
    output logic                 push,
    output csfd_pkg::frame_job_t job
);
    import csfd_pkg::*;

    localparam int SEEN_W = $clog2(FRAME_BYTES + 1);
    localparam logic [SEEN_W-1:0] SEEN_STORE = SEEN_W'(STORE_BYTES);
    localparam logic [SEEN_W-1:0] SEEN_CRC   = SEEN_W'(CRC_BYTES);
    localparam logic [SEEN_W-1:0] SEEN_CHECK = SEEN_W'(STORE_BYTES - 1);
    localparam logic [SEEN_W-1:0] SEEN_MAX   = SEEN_W'(FRAME_BYTES);

    logic [15:0]                     crc_reg;
    logic [15:0]                     crc_next;
    logic [SEEN_W-1:0]               seen_reg;
    logic [SEEN_W-1:0]               seen_next;
    logic [STORE_BYTES-1:0][7:0]     store_reg;
    logic [STORE_BYTES-1:0][7:0]     store_next;
    logic                            accept;
    logic                            ok;

    assign in_ready = !full;
    assign accept   = in_valid && in_ready;
    assign push     = accept && frame_end;

    always_comb
    begin
        store_next = store_reg;
        if (seen_reg < SEEN_STORE)
        begin
            store_next[seen_reg[STORE_IDX_W-1:0]] = byte_value;
        end
    end

    always_comb
    begin
        crc_next  = crc_reg;
        seen_next = seen_reg;
        if (accept)
        begin
            if (frame_end)
            begin
                crc_next  = CRC_INIT;
                seen_next = '0;
            end
            else
            begin
                if (seen_reg < SEEN_CRC)
                begin
                    crc_next = crc16_byte(crc_reg, byte_value);
                end
                if (seen_reg < SEEN_MAX)
                begin
                    seen_next = seen_reg + SEEN_W'(1);
                end
            end
        end
    end

    // Bytes 28 and 29 are outside the CRC, so the stored CRC is final here.
    assign ok = (seen_reg >= SEEN_CHECK) &&
                (crc_reg == {store_next[CRC_BYTES], store_next[CRC_BYTES + 1]});

    assign job.ok    = ok;
    assign job.bytes = store_next[JOB_BYTES-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg  <= CRC_INIT;
            seen_reg <= '0;
        end
        else
        begin
            crc_reg  <= crc_next;
            seen_reg <= seen_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            store_reg <= store_next;
        end
    end

endmodule

// ===== rtl/core/csfd_queue.sv =====
// ----------------------------------------------------------------------------
// csfd_queue
// Two-entry queue of checked frames between the front and the back.
// ----------------------------------------------------------------------------
module csfd_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  csfd_pkg::frame_job_t  job,
    input  logic                  pop,
    output logic                  full,
    output csfd_pkg::queue_head_t head
);
    import csfd_pkg::*;

    logic       v0_reg;
    logic       v0_next;
    logic       v1_reg;
    logic       v1_next;
    frame_job_t d0_reg;
    frame_job_t d0_next;
    frame_job_t d1_reg;
    frame_job_t d1_next;

    always_comb
    begin
        v0_next = v0_reg;
        v1_next = v1_reg;
        d0_next = d0_reg;
        d1_next = d1_reg;
        if (pop)
        begin
            v0_next = v1_reg;
            d0_next = d1_reg;
            v1_next = 1'b0;
        end
        if (push)
        begin
            if (!v0_next)
            begin
                v0_next = 1'b1;
                d0_next = job;
            end
            else
            begin
                v1_next = 1'b1;
                d1_next = job;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
        end
        else
        begin
            v0_reg <= v0_next;
            v1_reg <= v1_next;
        end
    end

    always_ff @(posedge clk)
    begin
        d0_reg <= d0_next;
        d1_reg <= d1_next;
    end

    assign full       = v1_reg;
    assign head.valid = v0_reg;
    assign head.job   = d0_reg;

endmodule

// ===== rtl/core/csfd_back.sv =====
// ----------------------------------------------------------------------------
// csfd_back
// Turns the frame at the head of the queue into records, placed in an output
// register one per cycle while the receiver keeps taking them.
// ----------------------------------------------------------------------------
module csfd_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  csfd_pkg::queue_head_t head,
    output logic                  pop,
    output logic                  out_valid,
    input  logic                  out_ready,
    output csfd_pkg::record_t     out_rec
);
    import csfd_pkg::*;

    rec_kind_t  idx_reg;
    rec_kind_t  idx_next;
    logic       valid_reg;
    logic       valid_next;
    record_t    rec_reg;
    record_t    rec_next;
    record_t    build;
    logic       load;
    logic       rec_last;
    job_bytes_t m;

    assign m        = head.job.bytes;
    assign load     = head.valid && (!valid_reg || out_ready);
    assign rec_last = !head.job.ok || (idx_reg == REC_PASS1);
    assign pop      = load && rec_last;

    always_comb
    begin
        build = '0;
        if (!head.job.ok)
        begin
            build.record_kind = REC_REJECT;
            build.last_record = 1'b1;
        end
        else
        begin
            build.record_kind = idx_reg;
            case (idx_reg)
                REC_GAME:
                begin
                    build.pos_x      = {m[3][3], m[12]};
                    build.pos_y      = {m[3][2], m[13]};
                    build.flag_bit   = m[3][1];
                    build.game_state = m[2][7:6];
                    build.value_word = {m[0], m[1]};
                end
                REC_CAR_A:
                begin
                    build.pos_x      = {m[2][3], m[4]};
                    build.pos_y      = {m[2][2], m[5]};
                    build.flag_bit   = m[2][5];
                    build.task_bit   = m[3][0];
                    build.value_word = {m[14], m[15]};
                    build.count_pick = m[18];
                    build.count_get  = m[20];
                    build.count_send = m[22];
                end
                REC_CAR_B:
                begin
                    build.pos_x      = {m[2][1], m[6]};
                    build.pos_y      = {m[2][0], m[7]};
                    build.flag_bit   = m[2][4];
                    build.task_bit   = ~m[3][0];
                    build.value_word = {m[16], m[17]};
                    build.count_pick = m[19];
                    build.count_get  = m[21];
                    build.count_send = m[23];
                end
                REC_PASS0:
                begin
                    build.pos_x = {m[3][7], m[8]};
                    build.pos_y = {m[3][6], m[9]};
                end
                REC_PASS1:
                begin
                    build.pos_x       = {m[3][5], m[10]};
                    build.pos_y       = {m[3][4], m[11]};
                    build.last_record = 1'b1;
                end
                default:
                begin
                    build.record_kind = REC_REJECT;
                    build.last_record = 1'b1;
                end
            endcase
        end
    end

    always_comb
    begin
        idx_next   = idx_reg;
        valid_next = valid_reg;
        rec_next   = rec_reg;
        if (load)
        begin
            valid_next = 1'b1;
            rec_next   = build;
            idx_next   = rec_last ? REC_GAME : rec_kind_t'(idx_reg + 3'd1);
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= REC_GAME;
            valid_reg <= 1'b0;
            rec_reg   <= '0;
        end
        else
        begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
            rec_reg   <= rec_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_rec   = rec_reg;

endmodule
